[rtl/srs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants
// Phase and mode codes, register reset values and the structs passed
// between the sequencer modules.
// ----------------------------------------------------------------------------
package srs_pkg;

  // sequence phases
  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_CMD_SNORE    = 4'd1;
  localparam logic [3:0] PH_WAIT_SNORE   = 4'd2;
  localparam logic [3:0] PH_HOLD         = 4'd3;
  localparam logic [3:0] PH_CMD_FLAT     = 4'd4;
  localparam logic [3:0] PH_WAIT_FLAT    = 4'd5;
  localparam logic [3:0] PH_PAUSE        = 4'd6;
  localparam logic [3:0] PH_WAIT_STARTUP = 4'd7;
  localparam logic [3:0] PH_WAIT_HOMING  = 4'd8;

  // run modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_ACTIVE  = 2'd1;
  localparam logic [1:0] MODE_LOCKOUT = 2'd3;

  // motor commands
  localparam logic [1:0] CMD_NONE     = 2'd0;
  localparam logic [1:0] CMD_GO_SNORE = 2'd1;
  localparam logic [1:0] CMD_GO_FLAT  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_HOLD_SECONDS     = 3'd0;
  localparam logic [2:0] REG_PAUSE_SECONDS    = 3'd1;
  localparam logic [2:0] REG_CYCLES_LOCKOUT   = 3'd2;
  localparam logic [2:0] REG_STARTUP_TICKS    = 3'd3;
  localparam logic [2:0] REG_TICKS_PER_SECOND = 3'd4;
  localparam logic [2:0] REG_TICKS_PER_MINUTE = 3'd5;
  localparam logic [2:0] REG_LOCKOUT_MINUTES  = 3'd6;

  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 3;

  // register reset values
  localparam logic [8:0]  HOLD_SECONDS_RST     = 9'd300;
  localparam logic [8:0]  PAUSE_SECONDS_RST    = 9'd60;
  localparam logic [3:0]  CYCLES_LOCKOUT_RST   = 4'd3;
  localparam logic [11:0] STARTUP_TICKS_RST    = 12'd3000;
  localparam logic [7:0]  TICKS_PER_SECOND_RST = 8'd200;
  localparam logic [13:0] TICKS_PER_MINUTE_RST = 14'd12000;
  localparam logic [8:0]  LOCKOUT_MINUTES_RST  = 9'd480;

  // saturation limits
  localparam logic [8:0]  SEC_MAX     = 9'd511;
  localparam logic [11:0] STARTUP_MAX = 12'd4095;

  typedef struct packed {
    logic [8:0]  hold_seconds;
    logic [8:0]  pause_seconds;
    logic [3:0]  cycles_before_lockout;
    logic [11:0] startup_ticks;
    logic [7:0]  ticks_per_second;
    logic [13:0] ticks_per_minute;
    logic [8:0]  lockout_minutes;
  } srs_cfg_t;

  typedef struct packed {
    logic [1:0] motor_command;
    logic       stop_demo;
    logic       auto_active;
    logic [3:0] sequence_phase;
  } srs_result_t;

endpackage

[rtl/srs_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_cfg_regs: configuration register file
// Seven write-only registers, loaded by index from the configuration port.
// ----------------------------------------------------------------------------
module srs_cfg_regs
  import srs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output srs_cfg_t              cfg
);

  srs_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_seconds          <= HOLD_SECONDS_RST;
      cfg_r.pause_seconds         <= PAUSE_SECONDS_RST;
      cfg_r.cycles_before_lockout <= CYCLES_LOCKOUT_RST;
      cfg_r.startup_ticks         <= STARTUP_TICKS_RST;
      cfg_r.ticks_per_second      <= TICKS_PER_SECOND_RST;
      cfg_r.ticks_per_minute      <= TICKS_PER_MINUTE_RST;
      cfg_r.lockout_minutes       <= LOCKOUT_MINUTES_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_HOLD_SECONDS:     cfg_r.hold_seconds          <= cfg_wdata[8:0];
        REG_PAUSE_SECONDS:    cfg_r.pause_seconds         <= cfg_wdata[8:0];
        REG_CYCLES_LOCKOUT:   cfg_r.cycles_before_lockout <= cfg_wdata[3:0];
        REG_STARTUP_TICKS:    cfg_r.startup_ticks         <= cfg_wdata[11:0];
        REG_TICKS_PER_SECOND: cfg_r.ticks_per_second      <= cfg_wdata[7:0];
        REG_TICKS_PER_MINUTE: cfg_r.ticks_per_minute      <= cfg_wdata[13:0];
        REG_LOCKOUT_MINUTES:  cfg_r.lockout_minutes       <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/srs_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_core: sequencer state and next-state logic
// Updates phase, mode and the tick/second/minute counters for one item
// per cycle while in_fire is high and presents the result for that item.
// ----------------------------------------------------------------------------
module srs_core
  import srs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic        kind,
  input  logic        snore_event,
  input  logic        motor_busy,
  input  logic        motors_homed,
  input  logic        key_pressed,
  input  logic        demo_running,
  input  srs_cfg_t    cfg,
  output srs_result_t res
);

  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        pend_r, pend_nxt;
  logic [11:0] start_cnt_r, start_cnt_nxt;
  logic [7:0]  sec_tick_r, sec_tick_nxt;
  logic [8:0]  sec_cnt_r, sec_cnt_nxt;
  logic [3:0]  cyc_cnt_r, cyc_cnt_nxt;
  logic [13:0] min_tick_r, min_tick_nxt;
  logic [8:0]  min_cnt_r, min_cnt_nxt;
  logic [1:0]  cmd;
  logic        stop;
  logic        tick_go;

  always_comb begin
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    pend_nxt      = pend_r | snore_event;
    start_cnt_nxt = start_cnt_r;
    sec_tick_nxt  = sec_tick_r;
    sec_cnt_nxt   = sec_cnt_r;
    cyc_cnt_nxt   = cyc_cnt_r;
    min_tick_nxt  = min_tick_r;
    min_cnt_nxt   = min_cnt_r;
    cmd           = CMD_NONE;
    stop          = 1'b0;
    tick_go       = 1'b0;

    if (kind) begin
      // control pass; nothing happens before arming
      if (phase_r < PH_WAIT_STARTUP) begin
        if (phase_r == PH_IDLE && pend_nxt) begin
          pend_nxt = 1'b0;
          if (!motor_busy && mode_r != MODE_LOCKOUT) begin
            phase_nxt = PH_CMD_SNORE;
            mode_nxt  = MODE_ACTIVE;
            stop      = demo_running;
          end
        end
        if (mode_nxt != MODE_ACTIVE) begin
          phase_nxt   = PH_IDLE;
          cyc_cnt_nxt = 4'd0;
        end else begin
          unique case (phase_nxt)
            PH_CMD_SNORE: begin
              phase_nxt = PH_WAIT_SNORE;
              cmd       = CMD_GO_SNORE;
            end
            PH_WAIT_SNORE: begin
              if (!motor_busy) begin
                sec_cnt_nxt = 9'd0;
                phase_nxt   = PH_HOLD;
              end
            end
            PH_HOLD: begin
              // a fresh snore restarts the hold
              if (pend_nxt) begin
                pend_nxt    = 1'b0;
                sec_cnt_nxt = 9'd0;
              end
              if (sec_cnt_nxt >= cfg.hold_seconds) begin
                phase_nxt   = PH_CMD_FLAT;
                sec_cnt_nxt = 9'd0;
              end
            end
            PH_CMD_FLAT: begin
              cmd       = CMD_GO_FLAT;
              phase_nxt = PH_WAIT_FLAT;
            end
            PH_WAIT_FLAT: begin
              if (!motor_busy) begin
                phase_nxt   = PH_PAUSE;
                sec_cnt_nxt = 9'd0;
                cyc_cnt_nxt = cyc_cnt_r + 4'd1;
                if (cyc_cnt_nxt >= cfg.cycles_before_lockout) begin
                  cyc_cnt_nxt = 4'd0;
                  mode_nxt    = MODE_LOCKOUT;
                end
              end
            end
            PH_PAUSE: begin
              if (sec_cnt_nxt >= cfg.pause_seconds) begin
                pend_nxt    = 1'b0;
                phase_nxt   = PH_IDLE;
                sec_cnt_nxt = 9'd0;
              end
            end
            default: ;
          endcase
        end
      end
    end else begin
      // timer tick
      tick_go = 1'b1;
      if (phase_r == PH_WAIT_HOMING) begin
        if (!motors_homed) tick_go = 1'b0;
        else phase_nxt = PH_WAIT_STARTUP;
      end
      if (tick_go && phase_nxt == PH_WAIT_STARTUP) begin
        if (start_cnt_r < STARTUP_MAX) start_cnt_nxt = start_cnt_r + 12'd1;
        pend_nxt = 1'b0;
        if (start_cnt_nxt >= cfg.startup_ticks) begin
          phase_nxt     = PH_IDLE;
          start_cnt_nxt = cfg.startup_ticks;
        end else begin
          tick_go = 1'b0;
        end
      end
      if (phase_nxt > PH_WAIT_HOMING) tick_go = 1'b0;
      if (tick_go) begin
        if (key_pressed) begin
          phase_nxt = PH_IDLE;
          mode_nxt  = MODE_OFF;
        end
        sec_tick_nxt = sec_tick_r + 8'd1;
        if (sec_tick_nxt >= cfg.ticks_per_second) begin
          sec_tick_nxt = 8'd0;
          if (sec_cnt_r < SEC_MAX) sec_cnt_nxt = sec_cnt_r + 9'd1;
        end
        if (mode_nxt == MODE_LOCKOUT) begin
          min_tick_nxt = min_tick_r + 14'd1;
          if (min_tick_nxt >= cfg.ticks_per_minute) begin
            min_tick_nxt = 14'd0;
            min_cnt_nxt  = min_cnt_r + 9'd1;
            if (min_cnt_nxt >= cfg.lockout_minutes) begin
              min_cnt_nxt = 9'd0;
              mode_nxt    = MODE_OFF;
            end
          end
        end else begin
          min_tick_nxt = 14'd0;
          min_cnt_nxt  = 9'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT_HOMING;
      mode_r      <= MODE_OFF;
      pend_r      <= 1'b0;
      start_cnt_r <= 12'd0;
      sec_tick_r  <= 8'd0;
      sec_cnt_r   <= 9'd0;
      cyc_cnt_r   <= 4'd0;
      min_tick_r  <= 14'd0;
      min_cnt_r   <= 9'd0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      pend_r      <= pend_nxt;
      start_cnt_r <= start_cnt_nxt;
      sec_tick_r  <= sec_tick_nxt;
      sec_cnt_r   <= sec_cnt_nxt;
      cyc_cnt_r   <= cyc_cnt_nxt;
      min_tick_r  <= min_tick_nxt;
      min_cnt_r   <= min_cnt_nxt;
    end
  end

  assign res.motor_command  = cmd;
  assign res.stop_demo      = stop;
  assign res.auto_active    = (mode_nxt == MODE_ACTIVE);
  assign res.sequence_phase = phase_nxt;

endmodule

[rtl/srs_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_out_buf: result register with skid stage
// Holds up to two results so the input side can take one more item after
// the receiver stalls; stall toward the input is registered.
// ----------------------------------------------------------------------------
module srs_out_buf
  import srs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  srs_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output srs_result_t out_data
);

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  srs_result_t out_data_r, out_data_nxt;
  srs_result_t skid_data_r, skid_data_nxt;
  logic        drain;

  assign drain = out_valid_r & ~out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (drain) begin
      if (skid_valid_r) begin
        // no push while the skid slot is occupied
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (!out_valid_r) begin
      out_valid_nxt = push;
      out_data_nxt  = push_data;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/snore_response_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snore_response_sequencer: anti-snore motor sequence controller
// Input items are timer ticks (kind 0) or control passes (kind 1); every
// item gives exactly one result item with the motor command, the demo
// stop request, the auto-run flag and the phase after that item.
//
// Channels use valid/stall; an item moves when valid is high and stall low.
// The seven setup registers are written through cfg_wr_en/cfg_index/
// cfg_wdata, only while no item is in flight: a user rule, not enforced.
//
// An item's result is registered before it reaches out_*. Throughput: one
// item per cycle while in_stall is low; the state update is a single pass
// of compare and increment logic from the state registers back into them.
// A two-entry result buffer sits at the output: when the receiver stalls,
// one more item is taken into the skid slot and then in_stall rises.
// Reset (synchronous, rst_n low) puts the registers at their defaults,
// the sequencer in the wait-for-homing phase with detection disabled, and
// empties the result buffer.
// ----------------------------------------------------------------------------
module snore_response_sequencer
  import srs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic                  in_snore_event,
  input  logic                  in_motor_busy,
  input  logic                  in_motors_homed,
  input  logic                  in_key_pressed,
  input  logic                  in_demo_running,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_motor_command,
  output logic                  out_stop_demo,
  output logic                  out_auto_active,
  output logic [3:0]            out_sequence_phase,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  srs_cfg_t    cfg;
  srs_result_t res;
  srs_result_t out_data;
  logic        buf_full;
  logic        in_fire;

  assign in_stall = buf_full;
  assign in_fire  = in_valid & ~buf_full;

  srs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  srs_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .kind         (in_kind),
    .snore_event  (in_snore_event),
    .motor_busy   (in_motor_busy),
    .motors_homed (in_motors_homed),
    .key_pressed  (in_key_pressed),
    .demo_running (in_demo_running),
    .cfg          (cfg),
    .res          (res)
  );

  srs_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_motor_command  = out_data.motor_command;
  assign out_stop_demo      = out_data.stop_demo;
  assign out_auto_active    = out_data.auto_active;
  assign out_sequence_phase = out_data.sequence_phase;

  // skid slot only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid slot occupied with empty output register");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sequence_phase <= PH_WAIT_HOMING))
    else $error("phase out of range");

  a_cmd_when_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_motor_command != CMD_NONE) |->
      (out_auto_active &&
       (out_motor_command == CMD_GO_SNORE || out_motor_command == CMD_GO_FLAT)))
    else $error("motor command outside an active run");

  a_stop_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stop_demo) |->
      (out_motor_command == CMD_GO_SNORE && out_sequence_phase == PH_WAIT_SNORE))
    else $error("demo stop without sequence start");

endmodule
